// ----- rtl/core/tad_word_stream_tokenizer_top_assert.svh -----
// Assertion macros used by the tokenizer parser RTL.
`ifndef TAD_WORD_STREAM_TOKENIZER_TOP_ASSERT_SVH
`define TAD_WORD_STREAM_TOKENIZER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define TAD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define TAD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/tad_wst_pkg.sv -----
// Shared types and constants of the word stream tokenizer.
`timescale 1ns / 1ps

package tad_wst_pkg;

   // Result kinds
   localparam logic [2:0] KIND_CHAR        = 3'd0;
   localparam logic [2:0] KIND_HEADER      = 3'd1;
   localparam logic [2:0] KIND_LENGTH_PART = 3'd2;
   localparam logic [2:0] KIND_LENGTH_DONE = 3'd3;
   localparam logic [2:0] KIND_PAYLOAD     = 3'd4;

   // Word codes
   localparam logic [15:0] HEADER_MASK   = 16'hFF80;
   localparam logic [15:0] LONG_LENGTH   = 16'hFFFF;
   localparam logic [31:0] CHAR_SIZE     = 32'd2;

   typedef struct packed {
      logic [15:0] text_word;
      logic        final_word;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] code;
      logic [7:0]  segment_id;
      logic [31:0] segment_size;
      logic        segment_done;
      logic        truncated;
   } rsp_payload_type;

   // Input register contents handed to the parser
   typedef struct packed {
      logic            valid;
      req_payload_type payload;
   } stage_type;

endpackage

// ----- rtl/core/tad_wst_if.sv -----
// Valid/ready channel interfaces for words in and results out.
`timescale 1ns / 1ps

interface tad_wst_req_if;
   import tad_wst_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface tad_wst_rsp_if;
   import tad_wst_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/tad_wst_ingress.sv -----
// Input register stage of the tokenizer.
`timescale 1ns / 1ps

module tad_wst_ingress (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  tad_wst_pkg::req_payload_type in_payload,
   output tad_wst_pkg::stage_type stage,
   input  logic                  stage_take
);
   import tad_wst_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   req_payload_type payload_ff;

   // Accept when empty or when the held word moves on this cycle
   assign in_ready = !valid_ff || stage_take;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Hold the word until the parser takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         payload_ff <= in_payload;
      end
   end

   assign stage.valid   = valid_ff;
   assign stage.payload = payload_ff;

endmodule

// ----- rtl/core/tad_wst_parse.sv -----
// Segment parser state and result register of the tokenizer.
`timescale 1ns / 1ps

module tad_wst_parse (
   input  logic                  clock,
   input  logic                  reset,
   input  tad_wst_pkg::stage_type stage,
   output logic                  stage_take,
   output logic                  out_valid,
   input  logic                  out_ready,
   output tad_wst_pkg::rsp_payload_type out_payload
);
   import tad_wst_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LEN,
      PH_LLO,
      PH_LHI,
      PH_PAY
   } phase_type;

   phase_type       phase_ff, phase_in;
   logic [30:0]     payload_left_ff, payload_left_in;
   logic [15:0]     long_low_ff, long_low_in;
   logic [7:0]      current_id_ff, current_id_in;
   logic [31:0]     seg_length_ff, seg_length_in;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic            out_free;
   logic            advance;
   logic [15:0]     word;
   logic [31:0]     begin_len;

   assign word     = stage.payload.text_word;
   assign out_free = !rsp_valid_ff || out_ready;
   assign advance  = stage.valid && out_free;
   assign stage_take = advance;

   // Pick the byte length that a completing length word delivers
   assign begin_len = (phase_ff == PH_LHI) ? {word, long_low_ff} : {16'd0, word};

   // Decode one word against the current phase
   always_comb begin
      phase_in        = phase_ff;
      payload_left_in = payload_left_ff;
      long_low_in     = long_low_ff;
      current_id_in   = current_id_ff;
      seg_length_in   = seg_length_ff;
      rsp_payload_in  = '0;
      rsp_payload_in.code = word;

      unique case (phase_ff)
         PH_LEN, PH_LHI: begin
            rsp_payload_in.segment_id = current_id_ff;
            if (phase_ff == PH_LEN && word == LONG_LENGTH) begin
               rsp_payload_in.kind = KIND_LENGTH_PART;
               phase_in = PH_LLO;
            end else begin
               rsp_payload_in.kind         = KIND_LENGTH_DONE;
               rsp_payload_in.segment_size = begin_len;
               seg_length_in   = begin_len;
               payload_left_in = begin_len[31:1];
               if (begin_len[31:1] == 31'd0) begin
                  rsp_payload_in.segment_done = 1'b1;
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_PAY;
               end
            end
         end
         PH_LLO: begin
            rsp_payload_in.segment_id = current_id_ff;
            rsp_payload_in.kind       = KIND_LENGTH_PART;
            long_low_in = word;
            phase_in    = PH_LHI;
         end
         PH_PAY: begin
            rsp_payload_in.segment_id   = current_id_ff;
            rsp_payload_in.kind         = KIND_PAYLOAD;
            rsp_payload_in.segment_size = seg_length_ff;
            payload_left_in = payload_left_ff - 31'd1;
            if (payload_left_ff == 31'd1) begin
               rsp_payload_in.segment_done = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            if ((word & HEADER_MASK) == HEADER_MASK) begin
               rsp_payload_in.kind       = KIND_HEADER;
               rsp_payload_in.segment_id = word[7:0];
               current_id_in = word[7:0];
               seg_length_in = 32'd0;
               phase_in      = PH_LEN;
            end else begin
               rsp_payload_in.kind         = KIND_CHAR;
               rsp_payload_in.segment_size = CHAR_SIZE;
               rsp_payload_in.segment_done = 1'b1;
               phase_in = PH_IDLE;
            end
         end
      endcase

      // Close the stream on the final word; flag an unfinished segment
      if (stage.payload.final_word) begin
         rsp_payload_in.truncated = (phase_in != PH_IDLE);
         phase_in        = PH_IDLE;
         payload_left_in = 31'd0;
      end
   end

   // Advance state and load the result on each transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         payload_left_ff <= 31'd0;
         long_low_ff     <= 16'd0;
         current_id_ff   <= 8'd0;
         seg_length_ff   <= 32'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff        <= phase_in;
            payload_left_ff <= payload_left_in;
            long_low_ff     <= long_low_in;
            current_id_ff   <= current_id_in;
            seg_length_ff   <= seg_length_in;
         end
         if (out_free) begin
            rsp_valid_ff <= stage.valid;
         end
      end
      if (advance) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign out_valid   = rsp_valid_ff;
   assign out_payload = rsp_payload_ff;

`include "tad_word_stream_tokenizer_top_assert.svh"

   `TAD_ASSERT_NOW(a_count_only_in_payload, phase_ff != PH_PAY, payload_left_ff == 31'd0,
      "payload count nonzero outside payload phase")
   `TAD_ASSERT_NOW(a_payload_count_live, phase_ff == PH_PAY, payload_left_ff != 31'd0,
      "payload phase with no words left")
   `TAD_ASSERT_NEXT(a_final_returns_idle, advance && stage.payload.final_word,
      phase_ff == PH_IDLE && rsp_valid_ff, "final word did not end the stream")
   `TAD_ASSERT_NEXT(a_stall_holds_phase, !advance, $stable(phase_ff),
      "phase moved without a transaction")

endmodule

// ----- rtl/core/tad_word_stream_tokenizer_top.sv -----
// Top level of the word stream tokenizer.
`timescale 1ns / 1ps
//
// Usage:
//   req_stream carries one 16-bit text word per transaction plus a flag for
//   the last word of the text. rsp_stream returns exactly one result per word:
//   kind, the echoed word, segment id, byte size, done and truncated flags.
//   Words are split into characters and segments (header, length words,
//   payload words); a 0xFFFF length is followed by a 32-bit length, low first.
// Pipeline and throughput:
//   An accepted word is held in the input register until the parser takes
//   it; the parser logic then loads its result into the result register.
//   One word per cycle is sustained while rsp_stream.ready stays high; the
//   rate is set by the parser, which decodes each word as one transaction.
// Reset:
//   Synchronous, active high; clears both registers' valid bits and returns
//   the parser to expect a header or character.
// Stall:
//   While rsp_stream.ready is low the result holds, the input register still
//   fills, and req_stream.ready drops once both stages are full.
//
module tad_word_stream_tokenizer_top (
   input  logic           clock,
   input  logic           reset,
   tad_wst_req_if.sink    req_stream,
   tad_wst_rsp_if.source  rsp_stream
);
   import tad_wst_pkg::*;

   stage_type stage;
   logic      stage_take;

   // Register the incoming word
   tad_wst_ingress u_ingress (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_stream.valid),
      .in_ready   (req_stream.ready),
      .in_payload (req_stream.payload),
      .stage      (stage),
      .stage_take (stage_take)
   );

   // Parse and register the result
   tad_wst_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .stage       (stage),
      .stage_take  (stage_take),
      .out_valid   (rsp_stream.valid),
      .out_ready   (rsp_stream.ready),
      .out_payload (rsp_stream.payload)
   );

endmodule
